/* rtl/q2r_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q2r_pkg
// Shared types and constants of the quaternion to rotation matrix block.
// ----------------------------------------------------------------------------
package q2r_pkg;

  localparam int unsigned CompW  = 16;
  localparam int unsigned NormW  = 33;   // sum of four squares
  localparam int unsigned NumW   = 34;   // signed element numerator
  localparam int unsigned QuotW  = 15;   // rounded quotient, 0..16384
  localparam int unsigned NumEl  = 9;
  localparam int unsigned DivIt  = 16;   // quotient bits developed per item
  localparam logic [QuotW-1:0] OneQ14 = 15'd16384;

  typedef logic signed [NumW-1:0] num_t;
  typedef logic signed [CompW-1:0] el_t;

  // One queued job: numerators of all nine elements, the common divisor and the degenerate flag.
  typedef struct packed {
    num_t [NumEl-1:0] num;
    logic [NormW-1:0] norm;
    logic             degen;
  } job_t;

  typedef struct packed {
    el_t [NumEl-1:0] el;
    logic            degen;
  } res_t;

endpackage

/* rtl/quaternion_to_rotation_matrix.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix
// Converts a Q1.15 quaternion into the nine Q2.14 rotation matrix elements.
// ----------------------------------------------------------------------------
// One quaternion is taken every cycle and one matrix leaves every cycle while
// the output is not stalled. Two stages form products and numerators, a
// two-entry queue follows, then sixteen stages of a pipelined divider (one
// quotient bit per stage, nine lanes sharing the norm as divisor) and an
// output register. An all-zero quaternion yields the identity and degenerate.
module quaternion_to_rotation_matrix import q2r_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               quat_valid_i,
  output logic               quat_ready_o,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  input  logic signed [15:0] quat_w_i,
  output logic               mat_valid_o,
  input  logic               mat_ready_i,
  output logic signed [15:0] r0c0_o,
  output logic signed [15:0] r0c1_o,
  output logic signed [15:0] r0c2_o,
  output logic signed [15:0] r1c0_o,
  output logic signed [15:0] r1c1_o,
  output logic signed [15:0] r1c2_o,
  output logic signed [15:0] r2c0_o,
  output logic signed [15:0] r2c1_o,
  output logic signed [15:0] r2c2_o,
  output logic               degenerate_o
);

  logic f_valid, f_ready, b_valid, b_ready;
  job_t f_job, b_job;
  res_t res;

  q2r_front u_front (
    .clk_i, .rst_ni,
    .valid_i(quat_valid_i), .ready_o(quat_ready_o),
    .x_i(quat_x_i), .y_i(quat_y_i), .z_i(quat_z_i), .w_i(quat_w_i),
    .valid_o(f_valid), .ready_i(f_ready), .job_o(f_job)
  );

  q2r_fifo u_fifo (
    .clk_i, .rst_ni,
    .valid_i(f_valid), .ready_o(f_ready), .data_i(f_job),
    .valid_o(b_valid), .ready_i(b_ready), .data_o(b_job)
  );

  q2r_back u_back (
    .clk_i, .rst_ni,
    .valid_i(b_valid), .ready_o(b_ready), .job_i(b_job),
    .valid_o(mat_valid_o), .ready_i(mat_ready_i), .res_o(res)
  );

  assign r0c0_o = res.el[0];
  assign r0c1_o = res.el[1];
  assign r0c2_o = res.el[2];
  assign r1c0_o = res.el[3];
  assign r1c1_o = res.el[4];
  assign r1c2_o = res.el[5];
  assign r2c0_o = res.el[6];
  assign r2c1_o = res.el[7];
  assign r2c2_o = res.el[8];
  assign degenerate_o = res.degen;

endmodule

/* rtl/q2r_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q2r_front
// Forms the products, numerators and squared norm of each quaternion over two
// registered stages and classifies the degenerate case.
// ----------------------------------------------------------------------------
module q2r_front import q2r_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  logic signed [CompW-1:0] x_i,
  input  logic signed [CompW-1:0] y_i,
  input  logic signed [CompW-1:0] z_i,
  input  logic signed [CompW-1:0] w_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output job_t                    job_o
);

  typedef logic signed [2*CompW-1:0] prod_t;

  logic  v1_q, v2_q;
  logic  adv1, adv2;
  prod_t xx_q, yy_q, zz_q, ww_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;
  prod_t xx_d, yy_d, zz_d, ww_d, xy_d, xz_d, yz_d, wx_d, wy_d, wz_d;
  job_t  job_q, job_d;

  assign adv2    = !v2_q || ready_i;
  assign adv1    = !v1_q || adv2;
  assign ready_o = adv1;
  assign valid_o = v2_q;
  assign job_o   = job_q;

  always_comb begin
    xx_d = x_i * x_i; yy_d = y_i * y_i; zz_d = z_i * z_i; ww_d = w_i * w_i;
    xy_d = x_i * y_i; xz_d = x_i * z_i; yz_d = y_i * z_i;
    wx_d = w_i * x_i; wy_d = w_i * y_i; wz_d = w_i * z_i;
  end

  always_comb begin
    logic signed [NumW-1:0] a, b, c, d;
    a = NumW'(xx_q); b = NumW'(yy_q); c = NumW'(zz_q); d = NumW'(ww_q);
    job_d.num[0] = d + a - b - c;
    job_d.num[1] = (NumW'(xy_q) + NumW'(wz_q)) <<< 1;
    job_d.num[2] = (NumW'(xz_q) - NumW'(wy_q)) <<< 1;
    job_d.num[3] = (NumW'(xy_q) - NumW'(wz_q)) <<< 1;
    job_d.num[4] = d - a + b - c;
    job_d.num[5] = (NumW'(yz_q) + NumW'(wx_q)) <<< 1;
    job_d.num[6] = (NumW'(xz_q) + NumW'(wy_q)) <<< 1;
    job_d.num[7] = (NumW'(yz_q) - NumW'(wx_q)) <<< 1;
    job_d.num[8] = d - a - b + c;
    job_d.norm   = NormW'(a + b + c + d);
    job_d.degen  = (xx_q == '0) && (yy_q == '0) && (zz_q == '0) && (ww_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= valid_i;
      if (adv2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && valid_i) begin
      xx_q <= xx_d; yy_q <= yy_d; zz_q <= zz_d; ww_q <= ww_d;
      xy_q <= xy_d; xz_q <= xz_d; yz_q <= yz_d;
      wx_q <= wx_d; wy_q <= wy_d; wz_q <= wz_d;
    end
    if (adv2 && v1_q) job_q <= job_d;
  end

endmodule

/* rtl/q2r_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q2r_fifo
// Short two-entry queue between the front and the divider back end.
// ----------------------------------------------------------------------------
module q2r_fifo import q2r_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  job_t data_i,
  output logic valid_o,
  input  logic ready_i,
  output job_t data_o
);

  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign ready_o = cnt_q != 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign push    = valid_i && ready_o;
  assign pop     = valid_o && ready_i;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (pop)  rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= data_i;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd0 |-> !pop) else $error("queue underflow");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + 2'd1) else $error("count slip");
`endif

endmodule

/* rtl/q2r_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q2r_back
// Pipelined restoring dividers, nine lanes sharing one divisor, one quotient
// bit per stage, with rounding built into the dividend, then sign and saturation.
// ----------------------------------------------------------------------------
module q2r_back import q2r_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  job_t job_i,
  output logic valid_o,
  input  logic ready_i,
  output res_t res_o
);

  // q = floor((mag*2^15 + n) / 2n); mag <= n, so q < 2^16.
  localparam int unsigned RemW = NormW + 2;

  logic [DivIt:0]                     v_q;
  logic [DivIt:0]                     adv;
  logic [DivIt:0][RemW-1:0]           d2_q;
  logic [DivIt:0]                     dg_q;
  logic [DivIt:0][NumEl-1:0]          sg_q;
  logic [DivIt:0][NumEl-1:0][RemW-1:0] rem_q;
  logic [DivIt:0][NumEl-1:0][DivIt-1:0] quo_q;
  logic [DivIt:0][NumEl-1:0][RemW-1:0] rem_d;
  logic [DivIt:0][NumEl-1:0][DivIt-1:0] quo_d;
  res_t out_q, out_d;
  logic ov_q;

  assign adv[DivIt] = !ov_q || ready_i;
  for (genvar s = DivIt - 1; s >= 0; s--) begin : g_adv
    assign adv[s] = !v_q[s] || adv[s+1];
  end
  assign ready_o = adv[0];
  assign valid_o = ov_q;
  assign res_o   = out_q;

  // Stage 0 input: the dividend's top part; its low bits are fed in from the quotient word.
  // Dividend = mag*2^15 + n; split it as hi = (mag*2^15+n) >> 16, low 16 bits.
  logic [NumEl-1:0][RemW+DivIt-1:0] dvd;
  always_comb begin
    for (int e = 0; e < NumEl; e++) begin
      logic [NumW-1:0] mag;
      mag    = job_i.num[e][NumW-1] ? NumW'(-job_i.num[e]) : NumW'(job_i.num[e]);
      dvd[e] = (RemW+DivIt)'({mag, 15'd0}) + (RemW+DivIt)'(job_i.norm);
    end
  end

  for (genvar s = 0; s < DivIt; s++) begin : g_stage
    always_comb begin
      for (int e = 0; e < NumEl; e++) begin
        logic [RemW:0] t;
        t = {rem_q[s][e], quo_q[s][e][DivIt-1]};
        if (t >= {1'b0, d2_q[s]}) begin
          rem_d[s+1][e] = RemW'(t - {1'b0, d2_q[s]});
          quo_d[s+1][e] = {quo_q[s][e][DivIt-2:0], 1'b1};
        end else begin
          rem_d[s+1][e] = RemW'(t);
          quo_d[s+1][e] = {quo_q[s][e][DivIt-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv[s+1] && v_q[s]) begin
        rem_q[s+1] <= rem_d[s+1];
        quo_q[s+1] <= quo_d[s+1];
        d2_q[s+1]  <= d2_q[s];
        dg_q[s+1]  <= dg_q[s];
        sg_q[s+1]  <= sg_q[s];
      end
    end
  end

  assign rem_d[0] = '0;
  assign quo_d[0] = '0;

  always_comb begin
    for (int e = 0; e < NumEl; e++) begin
      logic [DivIt-1:0] q;
      logic [QuotW-1:0] m;
      q = quo_q[DivIt][e];
      m = (q > DivIt'(OneQ14)) ? OneQ14 : QuotW'(q);
      if (dg_q[DivIt])
        out_d.el[e] = (e % 4 == 0) ? CompW'(OneQ14) : '0;
      else if (sg_q[DivIt][e])
        out_d.el[e] = -CompW'(m);
      else
        out_d.el[e] = CompW'(m);
    end
    out_d.degen = dg_q[DivIt];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q  <= '0;
      ov_q <= 1'b0;
    end else begin
      if (adv[0]) v_q[0] <= valid_i;
      for (int s = 0; s < DivIt; s++) begin
        if (adv[s+1]) v_q[s+1] <= v_q[s];
      end
      if (adv[DivIt]) ov_q <= v_q[DivIt];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0] && valid_i) begin
      for (int e = 0; e < NumEl; e++) begin
        rem_q[0][e] <= RemW'(dvd[e] >> DivIt);
        quo_q[0][e] <= dvd[e][DivIt-1:0];
        sg_q[0][e]  <= job_i.num[e][NumW-1];
      end
      d2_q[0] <= {1'b0, job_i.norm, 1'b0};
      dg_q[0] <= job_i.degen;
    end
    if (adv[DivIt] && v_q[DivIt]) out_q <= out_d;
  end

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !ready_i) |=> ov_q && $stable(out_q)) else $error("result lost");
  a_degen_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && out_q.degen) |-> out_q.el[0] == CompW'(OneQ14)) else $error("bad identity");
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> (out_q.el[4] <= $signed(CompW'(OneQ14))) &&
             (out_q.el[4] >= -$signed(CompW'(OneQ14)))) else $error("range");
`endif

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the quaternion to rotation matrix block. Random and
// directed quaternions are sent with bursty valid, the result side stalls on
// its own pattern, and every matrix is compared with an exact integer model.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct {
    logic signed [15:0] el [9];
    logic               degen;
  } matrix_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               quat_valid_i = 1'b0;
  logic               quat_ready_o;
  logic signed [15:0] quat_x_i = '0, quat_y_i = '0, quat_z_i = '0, quat_w_i = '0;
  logic               mat_valid_o;
  logic               mat_ready_i = 1'b0;
  logic signed [15:0] r0c0_o, r0c1_o, r0c2_o, r1c0_o, r1c1_o, r1c2_o;
  logic signed [15:0] r2c0_o, r2c1_o, r2c2_o;
  logic               degenerate_o;

  matrix_t     pending_mats [$];
  int unsigned n_errors = 0;
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned idle_cycles = 0;
  int unsigned gap_left = 0;
  bit          stall_enable = 1'b1;

  localparam int unsigned WatchdogLimit = 5000;

  always #4 clk_i = ~clk_i;

  quaternion_to_rotation_matrix i_dut (.*);

  // Round num * 2^14 / n to nearest, ties away from zero, then clamp.
  function automatic logic signed [15:0] scaled_ratio(longint num, longint n);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag * 32768 + n) / (2 * n);
    if (q > 16384) q = 16384;
    return (num < 0) ? 16'(-q) : 16'(q);
  endfunction

  function automatic matrix_t rotation_of(logic signed [15:0] qx, logic signed [15:0] qy,
                                          logic signed [15:0] qz, logic signed [15:0] qw);
    matrix_t m;
    longint x, y, z, w, xx, yy, zz, ww, n;
    x = qx; y = qy; z = qz; w = qw;
    xx = x * x; yy = y * y; zz = z * z; ww = w * w;
    n = xx + yy + zz + ww;
    if (n == 0) begin
      foreach (m.el[i]) m.el[i] = (i % 4 == 0) ? 16'sd16384 : 16'sd0;
      m.degen = 1'b1;
    end else begin
      m.el[0] = scaled_ratio(ww + xx - yy - zz, n);
      m.el[1] = scaled_ratio(2 * (x * y + w * z), n);
      m.el[2] = scaled_ratio(2 * (x * z - w * y), n);
      m.el[3] = scaled_ratio(2 * (x * y - w * z), n);
      m.el[4] = scaled_ratio(ww - xx + yy - zz, n);
      m.el[5] = scaled_ratio(2 * (y * z + w * x), n);
      m.el[6] = scaled_ratio(2 * (x * z + w * y), n);
      m.el[7] = scaled_ratio(2 * (y * z - w * x), n);
      m.el[8] = scaled_ratio(ww - xx - yy + zz, n);
      m.degen = 1'b0;
    end
    return m;
  endfunction

  // Drive one quaternion and hold it until the transfer. Gaps come in bursts.
  task automatic send_quat(logic signed [15:0] x, logic signed [15:0] y,
                           logic signed [15:0] z, logic signed [15:0] w);
    if (gap_left == 0 && $urandom_range(0, 15) == 0) gap_left = $urandom_range(1, 12);
    while (gap_left > 0) begin
      quat_valid_i <= 1'b0;
      @(posedge clk_i);
      gap_left--;
    end
    quat_x_i <= x; quat_y_i <= y; quat_z_i <= z; quat_w_i <= w;
    quat_valid_i <= 1'b1;
    do @(posedge clk_i); while (!quat_ready_o);
    pending_mats.push_back(rotation_of(x, y, z, w));
    n_sent++;
  endtask

  task automatic finish_send();
    quat_valid_i <= 1'b0;
  endtask

  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'(int'($urandom_range(0, 8)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    logic signed [15:0] ext [6] = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'sh0001,
                                    16'shffff, 16'sh4000};
    send_quat(0, 0, 0, 0);
    send_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_quat(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_quat(0, 0, 0, 16'sh7fff);
    send_quat(16'sh7fff, 0, 0, 0);
    send_quat(0, 16'sh8000, 0, 0);
    send_quat(0, 0, 16'sh0001, 0);
    send_quat(0, 0, 0, 16'shffff);
    send_quat(16'sh0001, 16'shffff, 16'sh0001, 16'shffff);
    send_quat(16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa);
    for (int i = 0; i < 12; i++)
      send_quat(ext[i % 6], ext[(i + 1) % 6], ext[(i + 3) % 6], ext[(i + 5) % 6]);
  endtask

  task automatic test_random(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if (i == count / 2) stall_enable = 1'b0;
      if (i == count * 3 / 4) stall_enable = 1'b1;
      send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
    end
    finish_send();
  endtask

  // Receiver stalls on a mask pattern, the mask being redrawn now and then.
  logic [7:0] stall_mask = 8'h00;
  logic [2:0] stall_phase = '0;
  always @(posedge clk_i) begin
    stall_phase <= stall_phase + 3'd1;
    if (stall_phase == 3'd0 && $urandom_range(0, 3) == 0) stall_mask <= 8'($urandom);
    mat_ready_i <= rst_ni && (!stall_enable || !stall_mask[stall_phase]);
  end

  always @(posedge clk_i) begin
    matrix_t exp_m;
    logic signed [15:0] got [9];
    if (rst_ni) begin
      if ((quat_valid_i && quat_ready_o) || (mat_valid_o && mat_ready_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (mat_valid_o && mat_ready_i) begin
        got = '{r0c0_o, r0c1_o, r0c2_o, r1c0_o, r1c1_o, r1c2_o, r2c0_o, r2c1_o, r2c2_o};
        if (pending_mats.size() == 0) begin
          $error("matrix transfer with nothing expected");
          n_errors++;
        end else begin
          exp_m = pending_mats.pop_front();
          foreach (got[i])
            if (got[i] !== exp_m.el[i]) begin
              $error("r%0dc%0d: expected %0d, got %0d", i / 3, i % 3, exp_m.el[i], got[i]);
              n_errors++;
            end
          if (degenerate_o !== exp_m.degen) begin
            $error("degenerate: expected %0b, got %0b", exp_m.degen, degenerate_o);
            n_errors++;
          end
          n_checked++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog: no transfer for %0d cycles", WatchdogLimit);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(1400);
    while (pending_mats.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("Sent %0d quaternions, checked %0d matrices, including zero and extremes.",
             n_sent, n_checked);
    if (n_errors == 0 && pending_mats.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/q2r_pkg.sv
rtl/q2r_front.sv
rtl/q2r_fifo.sv
rtl/q2r_back.sv
rtl/quaternion_to_rotation_matrix.sv
tb/tb_top.sv
